@@ rtl/hrf_pkg.sv @@
// ----------------------------------------------------------------------------
// hrf_pkg
// Shared types, codes and pattern helpers of the HTTP request framer.
// ----------------------------------------------------------------------------
package hrf_pkg;

    localparam int unsigned CFG_WIDTH = 24;

    // Register indexes of the configuration port
    localparam logic CFG_MAX_BYTES = 1'b0;
    localparam logic CFG_MAX_REQS  = 1'b1;

    // Report status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_METH  = 2'd1;
    localparam logic [1:0] ST_BAD_LEN   = 2'd2;
    localparam logic [1:0] ST_TOO_LARGE = 2'd3;

    // Parse phases
    localparam logic [1:0] PH_METHOD = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    localparam logic [2:0] MM_OK  = 3'd6;
    localparam logic [2:0] MM_BAD = 3'd7;

    // Content-Length value scan
    localparam logic [2:0] LF_NONE   = 3'd0;
    localparam logic [2:0] LF_SKIP   = 3'd1;
    localparam logic [2:0] LF_DIGITS = 3'd2;
    localparam logic [2:0] LF_DONE   = 3'd3;
    localparam logic [2:0] LF_BAD    = 3'd4;

    // Connection token matcher
    localparam logic [4:0] TK_START      = 5'd0;
    localparam logic [4:0] TK_CLOSE_FULL = 5'd5;
    localparam logic [4:0] TK_KEEP_BASE  = 5'd6;
    localparam logic [4:0] TK_KEEP_FULL  = 5'd15;
    localparam logic [4:0] TK_CLOSE_WS   = 5'd16;
    localparam logic [4:0] TK_KEEP_WS    = 5'd17;
    localparam logic [4:0] TK_OTHER      = 5'd18;
    localparam logic [4:0] TK_DONE       = 5'd19;

    localparam logic [1:0] CR_NONE  = 2'd0;
    localparam logic [1:0] CR_SEEN  = 2'd1;
    localparam logic [1:0] CR_CLOSE = 2'd2;
    localparam logic [1:0] CR_KEEP  = 2'd3;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic [8*15-1:0] PAT_LEN    = "Content-Length:";
    localparam logic [8*8-1:0]  PAT_VER    = "HTTP/1.0";
    localparam logic [8*11-1:0] PAT_CONN_A = "Connection:";
    localparam logic [8*11-1:0] PAT_CONN_B = "connection:";
    localparam logic [8*5-1:0]  PAT_CLOSE  = "close";
    localparam logic [8*10-1:0] PAT_KEEP   = "keep-alive";
    localparam logic [8*5-1:0]  PAT_POST   = "POST ";
    localparam logic [8*4-1:0]  PAT_GET    = "GET ";

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic        is_post;
        logic [23:0] body_length;
        logic [23:0] hdr_len;
        logic        keep_open;
        logic [7:0]  request_number;
    } t_report;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return c + 8'd32;
        end
        return c;
    endfunction

    // Patterns whose first character never recurs: fall back to one on it
    function automatic logic [3:0] len_next(input logic [3:0] q, input logic [7:0] c);
        if (q < 4'd15 && c == PAT_LEN[8*(14-int'(q)) +: 8]) begin
            return q + 4'd1;
        end
        return (c == "C") ? 4'd1 : 4'd0;
    endfunction

    function automatic logic [3:0] ver_next(input logic [3:0] q, input logic [7:0] c);
        if (q < 4'd8 && c == PAT_VER[8*(7-int'(q)) +: 8]) begin
            return q + 4'd1;
        end
        return (c == "H") ? 4'd1 : 4'd0;
    endfunction

    function automatic logic [3:0] key_next(input logic sel, input logic [3:0] q,
                                            input logic [7:0] c);
        logic [7:0] p;
        p = sel ? PAT_CONN_B[8*(10-int'(q)) +: 8] : PAT_CONN_A[8*(10-int'(q)) +: 8];
        if (c == p) begin
            return q + 4'd1;
        end
        if (sel && q == 4'd6 && c == "o") begin
            return 4'd2;
        end
        if (c == (sel ? 8'h63 : 8'h43)) begin
            return 4'd1;
        end
        return 4'd0;
    endfunction

    function automatic logic [1:0] end_next(input logic [1:0] q, input logic [7:0] c);
        case (q)
            2'd0:    return (c == CH_CR) ? 2'd1 : 2'd0;
            2'd1:    return (c == CH_LF) ? 2'd2 : (c == CH_CR) ? 2'd1 : 2'd0;
            2'd2:    return (c == CH_CR) ? 2'd3 : 2'd0;
            default: return (c == CH_CR) ? 2'd1 : 2'd0;
        endcase
    endfunction

    function automatic logic [4:0] tok_next(input logic [4:0] t, input logic [7:0] c);
        logic [7:0] l;
        l = to_lower(c);
        if (c == CH_CR || c == CH_LF) begin
            return TK_DONE;
        end else if (c == "," || c == ";") begin
            return TK_START;
        end else if (c == " " || c == 8'h09) begin
            if (t == TK_START) return TK_START;
            if (t == TK_CLOSE_FULL || t == TK_CLOSE_WS) return TK_CLOSE_WS;
            if (t == TK_KEEP_FULL || t == TK_KEEP_WS) return TK_KEEP_WS;
            return TK_OTHER;
        end else if (t == TK_START) begin
            return (l == "c") ? 5'd1 : (l == "k") ? TK_KEEP_BASE : TK_OTHER;
        end else if (t >= 5'd1 && t < TK_CLOSE_FULL) begin
            return (l == PAT_CLOSE[8*(4-int'(t)) +: 8]) ? t + 5'd1 : TK_OTHER;
        end else if (t >= TK_KEEP_BASE && t < TK_KEEP_FULL) begin
            return (l == PAT_KEEP[8*(14-int'(t)) +: 8]) ? t + 5'd1 : TK_OTHER;
        end
        return TK_OTHER;
    endfunction

    function automatic logic [1:0] res_next(input logic [1:0] r, input logic [4:0] t,
                                            input logic [7:0] c);
        if (c == CH_CR || c == CH_LF || c == "," || c == ";") begin
            if (t == TK_CLOSE_FULL || t == TK_CLOSE_WS) return CR_CLOSE;
            if (t == TK_KEEP_FULL || t == TK_KEEP_WS) return CR_KEEP;
        end
        return r;
    endfunction

endpackage

@@ rtl/hrf_core.sv @@
// ----------------------------------------------------------------------------
// hrf_core
// Parser state and the one-byte step: matchers, counters and report build.
// ----------------------------------------------------------------------------
module hrf_core import hrf_pkg::*; #(
    parameter int unsigned COUNT_WIDTH = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  logic                 i_new_conn,
    input  logic [CFG_WIDTH-1:0] i_max_bytes,
    input  logic [7:0]           i_max_reqs,
    output t_report              o_report
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [23:0] CAP = (COUNT_WIDTH >= 24) ? 24'hFFFFFF : 24'(COUNT_MAX);

    logic [1:0]             r_phase, n_phase;
    logic [2:0]             r_mm, n_mm;
    logic                   r_post, n_post;
    logic [1:0]             r_end, n_end;
    logic [3:0]             r_lkey, n_lkey;
    logic [23:0]            r_lval, n_lval;
    logic [2:0]             r_lflag, n_lflag;
    logic [3:0]             r_ver, n_ver;
    logic [3:0]             r_ckey [2], n_ckey [2];
    logic [4:0]             r_tok [2], n_tok [2];
    logic [1:0]             r_cres [2], n_cres [2];
    logic [COUNT_WIDTH-1:0] r_hc, n_hc;
    logic [COUNT_WIDTH-1:0] r_bc, n_bc;
    logic [7:0]             r_served, n_served;
    logic                   r_closed, n_closed;

    logic [23:0]            lim;
    logic [COUNT_WIDTH+1:0] total;
    logic [27:0]            lv_mul;
    logic                   do_err, do_fin, keep, sel;
    logic [1:0]             err_code;
    logic [3:0]             digit;
    logic                   ws;

    assign lim = (i_max_bytes > CAP) ? CAP : i_max_bytes;

    always_comb begin
        n_phase  = r_phase;   n_mm    = r_mm;    n_post  = r_post;
        n_end    = r_end;     n_lkey  = r_lkey;  n_lval  = r_lval;
        n_lflag  = r_lflag;   n_ver   = r_ver;   n_hc    = r_hc;
        n_bc     = r_bc;      n_served = r_served; n_closed = r_closed;
        n_ckey   = r_ckey;    n_tok   = r_tok;   n_cres  = r_cres;
        do_err   = 1'b0;      do_fin  = 1'b0;    err_code = ST_OK;
        keep     = 1'b0;      sel     = 1'b0;    total    = '0;
        lv_mul   = '0;        digit   = 4'd0;    ws       = 1'b0;
        o_report = '0;

        if (i_new_conn) begin
            n_phase = PH_METHOD; n_mm = 3'd0; n_post = 1'b0; n_end = 2'd0;
            n_lkey = 4'd0; n_lval = '0; n_lflag = LF_NONE; n_ver = 4'd0;
            n_ckey[0] = 4'd0; n_ckey[1] = 4'd0;
            n_tok[0] = TK_START; n_tok[1] = TK_START;
            n_cres[0] = CR_NONE; n_cres[1] = CR_NONE;
            n_hc = '0; n_bc = '0; n_served = 8'd0; n_closed = 1'b0;
        end

        if (!n_closed) begin
            total = {2'b00, n_hc} + {2'b00, n_bc} + (COUNT_WIDTH+2)'(1);
            if (total > (COUNT_WIDTH+2)'(lim)) begin
                do_err = 1'b1; err_code = ST_TOO_LARGE;
            end else if (n_phase == PH_BODY) begin
                n_bc = n_bc + 1'b1;
                if ((COUNT_WIDTH+1)'(n_bc) >= (COUNT_WIDTH+1)'(n_lval)) do_fin = 1'b1;
            end else begin
                n_hc = n_hc + 1'b1;
                // Method prefix
                if (n_phase == PH_METHOD) begin
                    if (n_mm == 3'd0) begin
                        if (i_byte == "P") begin
                            n_post = 1'b1; n_mm = 3'd1;
                        end else if (i_byte == "G") begin
                            n_post = 1'b0; n_mm = 3'd1;
                        end else begin
                            n_mm = MM_BAD;
                        end
                    end else if (n_mm < 3'd5) begin
                        if (n_post && i_byte == PAT_POST[8*(4-int'(n_mm)) +: 8])
                            n_mm = (n_mm == 3'd4) ? MM_OK : n_mm + 3'd1;
                        else if (!n_post && n_mm < 3'd4
                                 && i_byte == PAT_GET[8*(3-int'(n_mm)) +: 8])
                            n_mm = (n_mm == 3'd3) ? MM_OK : n_mm + 3'd1;
                        else
                            n_mm = MM_BAD;
                    end else if (n_mm != MM_OK) begin
                        n_mm = MM_BAD;
                    end
                    if (n_mm == MM_OK || n_mm == MM_BAD) n_phase = PH_HEADER;
                end
                // Connection headers, both spellings
                for (int i = 0; i < 2; i++) begin
                    if (n_ckey[i] == 4'd11) begin
                        if (n_tok[i] != TK_DONE) begin
                            n_cres[i] = res_next(n_cres[i], n_tok[i], i_byte);
                            n_tok[i]  = tok_next(n_tok[i], i_byte);
                        end
                    end else begin
                        n_ckey[i] = key_next(i[0], n_ckey[i], i_byte);
                        if (n_ckey[i] == 4'd11) begin
                            n_cres[i] = CR_SEEN; n_tok[i] = TK_START;
                        end
                    end
                end
                // Content-Length key and value
                if (n_lflag == LF_SKIP || n_lflag == LF_DIGITS) begin
                    ws = (i_byte == " " || (i_byte >= 8'h09 && i_byte <= CH_CR));
                    if (i_byte >= "0" && i_byte <= "9") begin
                        digit  = 4'(i_byte - "0");
                        lv_mul = {1'b0, n_lval, 3'b000} + {3'b000, n_lval, 1'b0}
                                 + {24'd0, digit};
                        if (lv_mul > {4'd0, lim}) begin
                            n_lflag = LF_BAD;
                        end else begin
                            n_lval = lv_mul[23:0]; n_lflag = LF_DIGITS;
                        end
                    end else if (n_lflag == LF_DIGITS) begin
                        n_lflag = LF_DONE;
                    end else if (!ws) begin
                        n_lflag = LF_BAD;
                    end
                end else if (n_lflag == LF_NONE) begin
                    n_lkey = len_next(n_lkey, i_byte);
                    if (n_lkey == 4'd15) begin
                        n_lflag = LF_SKIP; n_lval = '0;
                    end
                end
                if (n_ver < 4'd8) n_ver = ver_next(n_ver, i_byte);
                // Header end
                if (n_end == 2'd3 && i_byte == CH_LF) begin
                    if (n_lflag == LF_SKIP || n_lflag == LF_BAD) begin
                        do_err = 1'b1; err_code = ST_BAD_LEN;
                    end else begin
                        if (n_lflag == LF_DIGITS) n_lflag = LF_DONE;
                        if (n_phase == PH_METHOD) n_mm = MM_BAD;
                        if (n_lflag == LF_DONE && n_lval != '0) begin
                            n_phase = PH_BODY; n_bc = '0; n_end = 2'd0;
                        end else begin
                            do_fin = 1'b1;
                        end
                    end
                end else begin
                    n_end = end_next(n_end, i_byte);
                end
            end
        end

        if (do_fin && n_mm != MM_OK) begin
            do_fin = 1'b0; do_err = 1'b1; err_code = ST_BAD_METH;
        end

        if (do_err) begin
            o_report.valid          = 1'b1;
            o_report.status         = err_code;
            o_report.request_number = n_served;
            n_closed = 1'b1;
        end else if (do_fin) begin
            keep = (n_ver != 4'd8);
            sel  = (n_cres[0] == CR_NONE);
            if (n_cres[sel] == CR_CLOSE) keep = 1'b0;
            else if (n_cres[sel] == CR_KEEP) keep = 1'b1;
            if (!({1'b0, n_served} + 9'd1 < {1'b0, i_max_reqs})) keep = 1'b0;
            o_report.valid          = 1'b1;
            o_report.status         = ST_OK;
            o_report.is_post        = n_post;
            o_report.body_length    = (n_lflag == LF_DONE) ? n_lval : 24'd0;
            o_report.hdr_len        = 24'(n_hc);
            o_report.keep_open      = keep;
            o_report.request_number = n_served;
            if (n_served != 8'hFF) n_served = n_served + 8'd1;
            n_phase = PH_METHOD; n_mm = 3'd0; n_post = 1'b0; n_end = 2'd0;
            n_lkey = 4'd0; n_lval = '0; n_lflag = LF_NONE; n_ver = 4'd0;
            n_ckey[0] = 4'd0; n_ckey[1] = 4'd0;
            n_tok[0] = TK_START; n_tok[1] = TK_START;
            n_cres[0] = CR_NONE; n_cres[1] = CR_NONE;
            n_hc = '0; n_bc = '0;
            if (!keep) n_closed = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_METHOD; r_mm <= 3'd0; r_post <= 1'b0; r_end <= 2'd0;
            r_lkey <= 4'd0; r_lval <= '0; r_lflag <= LF_NONE; r_ver <= 4'd0;
            r_ckey[0] <= 4'd0; r_ckey[1] <= 4'd0;
            r_tok[0] <= TK_START; r_tok[1] <= TK_START;
            r_cres[0] <= CR_NONE; r_cres[1] <= CR_NONE;
            r_hc <= '0; r_bc <= '0; r_served <= 8'd0; r_closed <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase; r_mm <= n_mm; r_post <= n_post; r_end <= n_end;
            r_lkey <= n_lkey; r_lval <= n_lval; r_lflag <= n_lflag; r_ver <= n_ver;
            r_ckey <= n_ckey; r_tok <= n_tok; r_cres <= n_cres;
            r_hc <= n_hc; r_bc <= n_bc; r_served <= n_served; r_closed <= n_closed;
        end
    end

endmodule

@@ rtl/http_request_framer.sv @@
// ----------------------------------------------------------------------------
// http_request_framer
// Frames HTTP/1.1 requests from a byte stream and reports one result each.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_axis    | in        | tdata: data_byte; tuser: new_connection
//  m_axis    | out       | tdata: status, is_post, body/header length, keep, req no
//  cfg       | in        | index 0 max_request_bytes, 1 max_requests_per_connection
//
//  One byte per cycle unless m_axis stalls; a byte waits in the input register
//  and its report, if any, is loaded into the result register when it steps.
//  The per-byte step (all matchers and counters) sits between those registers.
//  Reset (synchronous, active low) clears parser state and valid flags and restores the config defaults.
//  A stall on m_axis holds the input register; tready drops only then.
module http_request_framer import hrf_pkg::*; #(
    parameter int unsigned COUNT_WIDTH = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [7:0]           i_s_tdata,  // [7:0] data_byte
    input  logic                 i_s_tuser,  // [0] new_connection
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [1:0] status, [2] is_post, [26:3] body_length, [50:27] hdr_len,
    // [51] keep_open, [59:52] request_number, [63:60] zero
    output logic [63:0]          o_m_tdata,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [CFG_WIDTH-1:0] i_cfg_wdata
);

    logic [CFG_WIDTH-1:0] r_max_bytes;
    logic [7:0]           r_max_reqs;
    logic                 r_in_valid;
    logic [7:0]           r_byte;
    logic                 r_new;
    logic                 r_out_valid;
    logic [63:0]          r_out_data;
    logic                 adv;
    logic                 step;
    t_report              report;

    // Advance the pipeline whenever the result register is free or draining
    assign adv        = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && adv;
    assign o_s_tready = !r_in_valid || adv;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= 24'd65536;
            r_max_reqs  <= 8'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_BYTES: r_max_bytes <= i_cfg_wdata;
                CFG_MAX_REQS:  r_max_reqs  <= i_cfg_wdata[7:0];
                default:       r_max_reqs  <= r_max_reqs;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_byte <= i_s_tdata;
            r_new  <= i_s_tuser;
        end
    end

    hrf_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_byte),
        .i_new_conn  (r_new),
        .i_max_bytes (r_max_bytes),
        .i_max_reqs  (r_max_reqs),
        .o_report    (report)
    );

    // Result register: load on every advance, drop bytes that give no report
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= step && report.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= {4'd0, report.request_number, report.keep_open,
                           report.hdr_len, report.body_length,
                           report.is_post, report.status};
        end
    end

endmodule

@@ rtl/hrf_checker.sv @@
// ----------------------------------------------------------------------------
// hrf_checker
// Port-level checks of the request framer, bound to the top level.
// ----------------------------------------------------------------------------
module hrf_checker import hrf_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata
);

    // Error reports carry only the request number
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[1:0] != ST_OK) |-> (o_m_tdata[51:2] == '0))
        else $error("error report with non-zero fields");

    // A framed request holds at least the blank line that ends the header
    a_hdr_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[1:0] == ST_OK) |-> (o_m_tdata[50:27] >= 24'd4))
        else $error("ok report with short header");

    // Nothing leaves in the cycle after reset
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid straight after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind http_request_framer hrf_checker u_hrf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
